/* hw/rtl/okot_pkg.sv */
// shared types and codes for the ordered key/owner table
package okot_pkg;

    localparam int OP_W    = 3;
    localparam int KEY_W   = 16;
    localparam int OWNER_W = 3;
    localparam int COUNT_W = 7;

    localparam logic [OP_W-1:0] OP_OCCUPY = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd2;
    localparam logic [OP_W-1:0] OP_COUNT  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [2:0] CELL_HOLD   = 3'd0;
    localparam logic [2:0] CELL_APPEND = 3'd1;
    localparam logic [2:0] CELL_MARK   = 3'd2;
    localparam logic [2:0] CELL_SETTLE = 3'd3;
    localparam logic [2:0] CELL_ROTATE = 3'd4;
    localparam logic [2:0] CELL_CLEAR  = 3'd5;

    typedef struct packed {
        logic [2:0] cmd;
        logic       tag_start;
    } cell_ctrl_t;

endpackage

/* hw/rtl/okot_cell.sv */
// one table cell: holds an entry and trades it with its neighbors
module okot_cell
    import okot_pkg::*;
#(
    parameter int KEY_BITS   = 16,
    parameter int OWNER_BITS = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_ctrl_t            ctrl,
    input  logic [KEY_BITS-1:0]   cmd_key,
    input  logic [OWNER_BITS-1:0] cmd_owner,
    input  logic                  left_valid,
    input  logic                  right_valid,
    input  logic [KEY_BITS-1:0]   right_key,
    input  logic [OWNER_BITS-1:0] right_owner,
    input  logic                  right_tag,
    input  logic [KEY_BITS-1:0]   wrap_key,
    input  logic [OWNER_BITS-1:0] wrap_owner,
    input  logic                  wrap_tag,
    output logic                  valid,
    output logic [KEY_BITS-1:0]   key,
    output logic [OWNER_BITS-1:0] owner,
    output logic                  tag
);

    logic                  valid_reg;
    logic                  valid_next;
    logic                  tag_reg;
    logic                  tag_next;
    logic [KEY_BITS-1:0]   key_reg;
    logic [KEY_BITS-1:0]   key_next;
    logic [OWNER_BITS-1:0] owner_reg;
    logic [OWNER_BITS-1:0] owner_next;

    always_comb
    begin
        valid_next = valid_reg;
        tag_next   = tag_reg;
        key_next   = key_reg;
        owner_next = owner_reg;
        unique case (ctrl.cmd)
            CELL_APPEND:
            begin
                // first free cell takes the new entry
                if (!valid_reg && left_valid)
                begin
                    valid_next = 1'b1;
                    key_next   = cmd_key;
                    owner_next = cmd_owner;
                end
            end
            CELL_MARK:
            begin
                if (valid_reg && key_reg == cmd_key)
                begin
                    valid_next = 1'b0;
                end
            end
            CELL_SETTLE:
            begin
                // a hole pulls from the right, an entry next to a hole gives itself up
                if (!valid_reg)
                begin
                    valid_next = right_valid;
                    key_next   = right_key;
                    owner_next = right_owner;
                    tag_next   = right_tag;
                end
                else if (!left_valid)
                begin
                    valid_next = 1'b0;
                end
            end
            CELL_ROTATE:
            begin
                // occupied cells rotate left, the last one takes the head entry
                if (valid_reg)
                begin
                    if (right_valid)
                    begin
                        key_next   = right_key;
                        owner_next = right_owner;
                        tag_next   = ctrl.tag_start ? 1'b0 : right_tag;
                    end
                    else
                    begin
                        key_next   = wrap_key;
                        owner_next = wrap_owner;
                        tag_next   = ctrl.tag_start ? 1'b1 : wrap_tag;
                    end
                end
            end
            CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tag_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            tag_reg   <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        owner_reg <= owner_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign owner = owner_reg;
    assign tag   = tag_reg;

endmodule

/* hw/rtl/ordered_key_owner_table_core.sv */
// top level of the ordered key/owner table: cell row and command sequencer
// occupy, clear and reserved codes: worked in the exec state, then the result loads
// remove: marks the matching entry, then compaction steps run until no hole is left
// lookup and count: exec examines the head entry, then scan steps run for one full
// rotation of the occupied cells past cell 0; one command is worked at a time and
// the next beat is taken the cycle after the result loads into the response register
// reset clears the valid flag of every cell at once, no clearing pass
module ordered_key_owner_table_core
    import okot_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int KEY_BITS   = 16,
    parameter int OWNER_BITS = 3
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  logic [OP_W-1:0]    operation,
    input  logic [KEY_W-1:0]   node_key,
    input  logic [OWNER_W-1:0] owner_id,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic               found,
    output logic [OWNER_W-1:0] found_owner,
    output logic [COUNT_W-1:0] owner_count,
    output logic               status
);

    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_EXEC    = 3'd1;
    localparam logic [2:0] ST_COMPACT = 3'd2;
    localparam logic [2:0] ST_SCAN    = 3'd3;
    localparam logic [2:0] ST_RESP    = 3'd4;

    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    logic                  settle_first_reg;
    logic                  settle_first_next;
    logic                  gap_reg;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;

    logic [OP_W-1:0]       op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [OWNER_BITS-1:0] owner_reg;

    logic                  found_reg;
    logic                  found_next;
    logic [OWNER_BITS-1:0] fowner_reg;
    logic [OWNER_BITS-1:0] fowner_next;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [CNT_BITS-1:0]   cnt_next;

    logic                  res_found_reg;
    logic [OWNER_BITS-1:0] res_fowner_reg;
    logic [CNT_BITS-1:0]   res_cnt_reg;
    logic                  res_status_reg;

    logic                  rsp_found_reg;
    logic [OWNER_W-1:0]    rsp_fowner_reg;
    logic [COUNT_W-1:0]    rsp_cnt_reg;
    logic                  rsp_status_reg;

    logic                  fin_valid;
    logic                  fin_found;
    logic [OWNER_BITS-1:0] fin_fowner;
    logic [CNT_BITS-1:0]   fin_cnt;
    logic                  fin_status;

    logic                  cmd_accept;
    logic                  out_free;
    logic                  rsp_load;
    logic                  res_load;
    logic                  table_full;
    logic                  key_hit;
    logic                  owner_hit;
    logic                  gap_any;

    cell_ctrl_t            cell_ctrl;

    logic [CAPACITY-1:0]   cell_valid;
    logic [CAPACITY-1:0]   cell_tag;
    logic [CAPACITY-2:0]   gap_vec;
    logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
    logic [OWNER_BITS-1:0] cell_owner [CAPACITY];

    // cell row
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                  left_v;
        logic                  right_v;
        logic [KEY_BITS-1:0]   right_k;
        logic [OWNER_BITS-1:0] right_o;
        logic                  right_t;

        if (i == 0)
        begin : g_head
            assign left_v = 1'b1;
        end
        else
        begin : g_body
            assign left_v = cell_valid[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_v = 1'b0;
            assign right_k = '0;
            assign right_o = '0;
            assign right_t = 1'b0;
        end
        else
        begin : g_link
            assign right_v    = cell_valid[i+1];
            assign right_k    = cell_key[i+1];
            assign right_o    = cell_owner[i+1];
            assign right_t    = cell_tag[i+1];
            assign gap_vec[i] = !cell_valid[i] && cell_valid[i+1];
        end

        okot_cell #(
            .KEY_BITS   (KEY_BITS),
            .OWNER_BITS (OWNER_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl),
            .cmd_key     (key_reg),
            .cmd_owner   (owner_reg),
            .left_valid  (left_v),
            .right_valid (right_v),
            .right_key   (right_k),
            .right_owner (right_o),
            .right_tag   (right_t),
            .wrap_key    (cell_key[0]),
            .wrap_owner  (cell_owner[0]),
            .wrap_tag    (cell_tag[0]),
            .valid       (cell_valid[i]),
            .key         (cell_key[i]),
            .owner       (cell_owner[i]),
            .tag         (cell_tag[i])
        );
    end

    assign gap_any    = |gap_vec;
    assign table_full = cell_valid[CAPACITY-1];
    assign key_hit    = cell_valid[0] && (cell_key[0] == key_reg);
    assign owner_hit  = cell_valid[0] && (cell_owner[0] == owner_reg);

    assign cmd_stall  = (state_reg != ST_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign out_free   = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next        = state_reg;
        settle_first_next = settle_first_reg;
        cell_ctrl         = '{cmd: CELL_HOLD, tag_start: 1'b0};
        found_next        = found_reg;
        fowner_next       = fowner_reg;
        cnt_next          = cnt_reg;
        fin_valid         = 1'b0;
        fin_found         = 1'b0;
        fin_fowner        = '0;
        fin_cnt           = '0;
        fin_status        = 1'b0;
        rsp_load          = 1'b0;
        res_load          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (op_reg) inside
                    OP_OCCUPY:
                    begin
                        fin_valid = 1'b1;
                        if (table_full)
                        begin
                            fin_status = 1'b1;
                        end
                        else
                        begin
                            cell_ctrl.cmd = CELL_APPEND;
                        end
                    end
                    OP_REMOVE:
                    begin
                        cell_ctrl.cmd     = CELL_MARK;
                        settle_first_next = 1'b1;
                        state_next        = ST_COMPACT;
                    end
                    OP_LOOKUP, OP_COUNT:
                    begin
                        if (!cell_valid[0])
                        begin
                            fin_valid = 1'b1;
                        end
                        else
                        begin
                            // examine the head entry and tag it as it wraps
                            cell_ctrl   = '{cmd: CELL_ROTATE, tag_start: 1'b1};
                            found_next  = key_hit;
                            fowner_next = key_hit ? cell_owner[0] : '0;
                            cnt_next    = CNT_BITS'(owner_hit);
                            state_next  = ST_SCAN;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cell_ctrl.cmd = CELL_CLEAR;
                        fin_valid     = 1'b1;
                    end
                    default:
                    begin
                        fin_valid = 1'b1;
                    end
                endcase
            end
            ST_COMPACT:
            begin
                // gap flag is registered, so the first step is never the last
                cell_ctrl.cmd     = CELL_SETTLE;
                settle_first_next = 1'b0;
                if (!settle_first_reg && !gap_reg)
                begin
                    fin_valid = 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (cell_tag[0])
                begin
                    fin_valid = 1'b1;
                    if (op_reg == OP_LOOKUP)
                    begin
                        fin_found  = found_reg;
                        fin_fowner = fowner_reg;
                    end
                    else
                    begin
                        fin_cnt = cnt_reg;
                    end
                end
                else
                begin
                    cell_ctrl.cmd = CELL_ROTATE;
                    if (!found_reg && key_hit)
                    begin
                        found_next  = 1'b1;
                        fowner_next = cell_owner[0];
                    end
                    cnt_next = cnt_reg + CNT_BITS'(owner_hit);
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (fin_valid)
        begin
            if (out_free)
            begin
                rsp_load   = 1'b1;
                state_next = ST_IDLE;
            end
            else
            begin
                res_load   = 1'b1;
                state_next = ST_RESP;
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load || (state_reg == ST_RESP && out_free))
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            settle_first_reg <= 1'b0;
            gap_reg          <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            settle_first_reg <= settle_first_next;
            gap_reg          <= gap_any;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            op_reg    <= operation;
            key_reg   <= KEY_BITS'(node_key);
            owner_reg <= OWNER_BITS'(owner_id);
        end
        found_reg  <= found_next;
        fowner_reg <= fowner_next;
        cnt_reg    <= cnt_next;
        if (res_load)
        begin
            res_found_reg  <= fin_found;
            res_fowner_reg <= fin_fowner;
            res_cnt_reg    <= fin_cnt;
            res_status_reg <= fin_status;
        end
        if (rsp_load)
        begin
            rsp_found_reg  <= fin_found;
            rsp_fowner_reg <= OWNER_W'(fin_fowner);
            rsp_cnt_reg    <= COUNT_W'(fin_cnt);
            rsp_status_reg <= fin_status;
        end
        else if (state_reg == ST_RESP && out_free)
        begin
            rsp_found_reg  <= res_found_reg;
            rsp_fowner_reg <= OWNER_W'(res_fowner_reg);
            rsp_cnt_reg    <= COUNT_W'(res_cnt_reg);
            rsp_status_reg <= res_status_reg;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign found       = rsp_found_reg;
    assign found_owner = rsp_fowner_reg;
    assign owner_count = rsp_cnt_reg;
    assign status      = rsp_status_reg;

    // occupied cells always form a solid prefix between commands
    a_compact_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !gap_any)
        else $error("table has a hole while idle");

    // a rotation only runs over a non-empty table with one marked head entry
    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> cell_valid[0] && $onehot(cell_tag & cell_valid))
        else $error("scan lost its head mark");

    // a successful occupy grows the table by exactly one entry
    a_occupy_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && op_reg == OP_OCCUPY && !table_full) |=>
        ($countones(cell_valid) == $past($countones(cell_valid)) + 1))
        else $error("occupy did not add one entry");

    // rotation never changes how many entries are held
    a_rotate_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=>
        ($countones(cell_valid) == $past($countones(cell_valid))))
        else $error("scan changed the entry count");

endmodule
